[hdl/grbyuv_pkg.sv]
`default_nettype none
package grbyuv_pkg;

  // Glyph geometry
  localparam int GLYPH_WIDTH  = 11;
  localparam int GLYPH_HEIGHT = 14;

  // Field widths
  localparam int COORD_W   = 13;
  localparam int ROFF_W    = 4;
  localparam int BITS_W    = 32;
  localparam int ADDR_W    = 32;
  localparam int DIM_W     = 12;
  localparam int STRIDE_W  = 16;
  localparam int PAL_W     = 24;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;
  localparam int COL_W     = 4;   // glyph column index, holds up to 15
  localparam int PROD_W    = DIM_W + STRIDE_W;

  // Register reset values
  localparam logic [DIM_W-1:0]    FB_WIDTH_RST   = 12'd640;
  localparam logic [DIM_W-1:0]    FB_HEIGHT_RST  = 12'd480;
  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST = 16'd1280;
  localparam logic [PAL_W-1:0]    PAL0_RST       = 24'h108080;
  localparam logic [PAL_W-1:0]    PAL1_RST       = 24'h468080;
  localparam logic [PAL_W-1:0]    PAL2_RST       = 24'h7C8080;
  localparam logic [PAL_W-1:0]    PAL3_RST       = 24'hB38080;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FB_WIDTH   = 3'd0,
    CFG_FB_HEIGHT  = 3'd1,
    CFG_ROW_STRIDE = 3'd2,
    CFG_PAL_ZERO   = 3'd3,
    CFG_PAL_ONE    = 3'd4,
    CFG_PAL_TWO    = 3'd5,
    CFG_PAL_THREE  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0]          fb_width;
    logic [DIM_W-1:0]          fb_height;
    logic [STRIDE_W-1:0]       row_stride;
    logic [3:0][PAL_W-1:0]     palette;
  } cfg_t;

  // One drawable row as handed from the front to the back
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [COL_W-1:0]  c_first;
    logic [COL_W-1:0]  c_last;
    logic              col_odd;
    logic [BITS_W-1:0] bits;
  } desc_t;

endpackage
`default_nettype wire

[hdl/grbyuv_if.sv]
`default_nettype none
interface grbyuv_item_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [grbyuv_pkg::COORD_W-1:0]   glyph_x;
  logic signed [grbyuv_pkg::COORD_W-1:0]   glyph_y;
  logic [grbyuv_pkg::ROFF_W-1:0]           row_offset;
  logic [grbyuv_pkg::BITS_W-1:0]           row_bits;
  logic                                    interlaced;
  logic                                    field_parity;
  logic [grbyuv_pkg::ADDR_W-1:0]           base_address;

  modport source (output valid, glyph_x, glyph_y, row_offset, row_bits, interlaced,
                  field_parity, base_address, input ready);
  modport sink (input valid, glyph_x, glyph_y, row_offset, row_bits, interlaced,
                field_parity, base_address, output ready);
endinterface

interface grbyuv_wr_if;
  logic                              valid;
  logic                              ready;
  logic [grbyuv_pkg::ADDR_W-1:0]     write_address;
  logic [grbyuv_pkg::BYTE_W-1:0]     luma_byte;
  logic [grbyuv_pkg::BYTE_W-1:0]     chroma_byte;
  logic                              last_write;

  modport source (output valid, write_address, luma_byte, chroma_byte, last_write,
                  input ready);
  modport sink (input valid, write_address, luma_byte, chroma_byte, last_write,
                output ready);
endinterface

interface grbyuv_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [grbyuv_pkg::CFG_IDX_W-1:0]    index;
  logic [grbyuv_pkg::CFG_DAT_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/glyph_row_blit_yuv422_core.sv]
// An accepted row passes clip, multiply, queue and pixel unit to its output register.
// Throughput: one write per cycle while the write sink is ready; one write per visible pixel.
// Rows that clip away entirely are dropped at the clip stage and take no pixel-unit time.
// The pixel unit (one palette lookup per cycle while the sink is ready) sets the sustained rate.
// Reset: asynchronous, active low; empties the pipeline and queue and loads register defaults.
`default_nettype none
module glyph_row_blit_yuv422_core (
  input  wire           clk_i,
  input  wire           rst_ni,
  grbyuv_item_if.sink   item_i,
  grbyuv_cfg_if.sink    cfg_i,
  grbyuv_wr_if.source   wr_o
);

  grbyuv_pkg::cfg_t  cfg_q;
  grbyuv_pkg::desc_t push_desc, head_desc;
  logic              push, push_ready, pop_valid, pop;

  // Register writes are never stalled: ready is tied high
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fb_width   <= grbyuv_pkg::FB_WIDTH_RST;
      cfg_q.fb_height  <= grbyuv_pkg::FB_HEIGHT_RST;
      cfg_q.row_stride <= grbyuv_pkg::ROW_STRIDE_RST;
      cfg_q.palette[0] <= grbyuv_pkg::PAL0_RST;
      cfg_q.palette[1] <= grbyuv_pkg::PAL1_RST;
      cfg_q.palette[2] <= grbyuv_pkg::PAL2_RST;
      cfg_q.palette[3] <= grbyuv_pkg::PAL3_RST;
    end else if (cfg_i.valid) begin
      case (grbyuv_pkg::cfg_idx_e'(cfg_i.index))
        grbyuv_pkg::CFG_FB_WIDTH:   cfg_q.fb_width   <= cfg_i.data[11:0];
        grbyuv_pkg::CFG_FB_HEIGHT:  cfg_q.fb_height  <= cfg_i.data[11:0];
        grbyuv_pkg::CFG_ROW_STRIDE: cfg_q.row_stride <= cfg_i.data[15:0];
        grbyuv_pkg::CFG_PAL_ZERO:   cfg_q.palette[0] <= cfg_i.data;
        grbyuv_pkg::CFG_PAL_ONE:    cfg_q.palette[1] <= cfg_i.data;
        grbyuv_pkg::CFG_PAL_TWO:    cfg_q.palette[2] <= cfg_i.data;
        grbyuv_pkg::CFG_PAL_THREE:  cfg_q.palette[3] <= cfg_i.data;
        default: begin
          // unmapped index: drop the beat
        end
      endcase
    end
  end

  // Front: clip the row against the screen and field, form the start address
  grbyuv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .cfg_i        (cfg_q),
    .push_o       (push),
    .desc_o       (push_desc),
    .push_ready_i (push_ready)
  );

  // Two-deep queue decouples row classification from pixel emission
  grbyuv_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .desc_i       (push_desc),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .desc_o       (head_desc),
    .pop_i        (pop)
  );

  // Back: walk visible columns, one palette write per beat, flag the last
  grbyuv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .desc_i      (head_desc),
    .pop_o       (pop),
    .wr_o        (wr_o)
  );

endmodule
`default_nettype wire

[hdl/grbyuv_front.sv]
`default_nettype none
module grbyuv_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  grbyuv_item_if.sink           item_i,
  input  grbyuv_pkg::cfg_t      cfg_i,
  output logic                  push_o,
  output grbyuv_pkg::desc_t     desc_o,
  input  wire                   push_ready_i
);

  // Stage 1: classify and clip
  logic                                 s1_v_q;
  logic [grbyuv_pkg::DIM_W-1:0]         s1_row_q;
  logic [grbyuv_pkg::DIM_W-1:0]         s1_col_q;
  logic [grbyuv_pkg::COL_W-1:0]         s1_cf_q;
  logic [grbyuv_pkg::COL_W-1:0]         s1_cl_q;
  logic [grbyuv_pkg::BITS_W-1:0]        s1_bits_q;
  logic [grbyuv_pkg::ADDR_W-1:0]        s1_base_q;

  // Stage 2: row multiply
  logic                                 s2_v_q;
  logic [grbyuv_pkg::PROD_W-1:0]        s2_prod_q;
  logic [grbyuv_pkg::ADDR_W-1:0]        s2_base_q;
  logic [grbyuv_pkg::COL_W-1:0]         s2_cf_q;
  logic [grbyuv_pkg::COL_W-1:0]         s2_cl_q;
  logic                                 s2_odd_q;
  logic [grbyuv_pkg::BITS_W-1:0]        s2_bits_q;

  logic        s2_ready, s1_ready, accept;
  logic [13:0] line, gx_ext, wid, neg;
  logic        roff_ok, line_ok, par_ok, lo_ok, hi_ok, keep;
  logic [grbyuv_pkg::DIM_W-1:0] row;
  logic [grbyuv_pkg::COL_W-1:0] c_first, c_last;
  logic [13:0] col_first;

  assign s2_ready     = !s2_v_q || push_ready_i;
  assign s1_ready     = !s1_v_q || s2_ready;
  assign item_i.ready = s1_ready;
  assign accept       = item_i.valid && s1_ready;

  always_comb begin
    line    = {item_i.glyph_y[12], item_i.glyph_y} + {10'd0, item_i.row_offset};
    roff_ok = {1'b0, item_i.row_offset} < 5'(grbyuv_pkg::GLYPH_HEIGHT);
    line_ok = !line[13] && (line[12:0] < {1'b0, cfg_i.fb_height});
    par_ok  = !item_i.interlaced || (line[0] == item_i.field_parity);
    row     = item_i.interlaced ? {1'b0, line[11:1]} : line[11:0];

    gx_ext  = {item_i.glyph_x[12], item_i.glyph_x};
    neg     = 14'd0 - gx_ext;
    wid     = {2'b00, cfg_i.fb_width} - gx_ext;

    // leftmost glyph column on screen
    if (gx_ext[13]) begin
      lo_ok   = neg[12:0] < 13'(grbyuv_pkg::GLYPH_WIDTH);
      c_first = neg[grbyuv_pkg::COL_W-1:0];
    end else begin
      lo_ok   = 1'b1;
      c_first = '0;
    end

    // rightmost glyph column left of the right edge
    hi_ok = !wid[13] && (wid != 14'd0);
    if (wid[12:0] >= 13'(grbyuv_pkg::GLYPH_WIDTH)) begin
      c_last = grbyuv_pkg::COL_W'(grbyuv_pkg::GLYPH_WIDTH - 1);
    end else begin
      c_last = wid[grbyuv_pkg::COL_W-1:0] - grbyuv_pkg::COL_W'(1);
    end

    col_first = gx_ext + {10'd0, c_first};
    keep = roff_ok && line_ok && par_ok && lo_ok && hi_ok && (c_first <= c_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= accept && keep;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_row_q  <= row;
      s1_col_q  <= col_first[grbyuv_pkg::DIM_W-1:0];
      s1_cf_q   <= c_first;
      s1_cl_q   <= c_last;
      s1_bits_q <= item_i.row_bits;
      s1_base_q <= item_i.base_address;
    end
    if (s2_ready) begin
      s2_prod_q <= s1_row_q * cfg_i.row_stride;
      s2_base_q <= s1_base_q + {19'd0, s1_col_q, 1'b0};
      s2_cf_q   <= s1_cf_q;
      s2_cl_q   <= s1_cl_q;
      s2_odd_q  <= s1_col_q[0];
      s2_bits_q <= s1_bits_q;
    end
  end

  assign push_o         = s2_v_q;
  assign desc_o.addr    = s2_base_q + {4'd0, s2_prod_q};
  assign desc_o.c_first = s2_cf_q;
  assign desc_o.c_last  = s2_cl_q;
  assign desc_o.col_odd = s2_odd_q;
  assign desc_o.bits    = s2_bits_q;

`ifndef SYNTHESIS
  a_s1_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> (s1_cf_q <= s1_cl_q) &&
               (s1_cl_q < grbyuv_pkg::COL_W'(grbyuv_pkg::GLYPH_WIDTH)))
    else $error("front: clipped column range is empty or past the glyph");
`endif

endmodule
`default_nettype wire

[hdl/grbyuv_fifo.sv]
`default_nettype none
module grbyuv_fifo (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  grbyuv_pkg::desc_t     desc_i,
  output logic                  push_ready_o,
  output logic                  pop_valid_o,
  output grbyuv_pkg::desc_t     desc_o,
  input  wire                   pop_i
);

  grbyuv_pkg::desc_t mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              do_push, do_pop;

  assign pop_valid_o  = count_q != 2'd0;
  assign push_ready_o = (count_q != 2'd2) || pop_i;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign desc_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("fifo: occupancy beyond depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("fifo: pointers disagree with occupancy");
`endif

endmodule
`default_nettype wire

[hdl/grbyuv_back.sv]
`default_nettype none
module grbyuv_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  grbyuv_pkg::cfg_t      cfg_i,
  input  wire                   pop_valid_i,
  input  grbyuv_pkg::desc_t     desc_i,
  output logic                  pop_o,
  grbyuv_wr_if.source           wr_o
);

  logic                             busy_q;
  logic [grbyuv_pkg::ADDR_W-1:0]    addr_q;
  logic [grbyuv_pkg::COL_W-1:0]     c_q, cl_q;
  logic                             odd_q;
  logic [grbyuv_pkg::BITS_W-1:0]    bits_q;

  logic                             out_v_q;
  logic [grbyuv_pkg::ADDR_W-1:0]    out_addr_q;
  logic [grbyuv_pkg::BYTE_W-1:0]    out_luma_q, out_chroma_q;
  logic                             out_last_q;

  logic                             out_free, fire, last_px;
  logic [grbyuv_pkg::BITS_W-1:0]    sh;
  logic [1:0]                       pix;
  logic [grbyuv_pkg::PAL_W-1:0]     ent;

  assign out_free = !out_v_q || wr_o.ready;
  assign fire     = busy_q && out_free;
  assign last_px  = c_q == cl_q;
  assign pop_o    = pop_valid_i && (!busy_q || (fire && last_px));

  always_comb begin
    sh  = bits_q >> (5'd30 - {c_q, 1'b0});
    pix = sh[1:0];
    ent = cfg_i.palette[pix];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (fire && last_px) begin
        busy_q <= 1'b0;
      end
      if (out_free) begin
        out_v_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      addr_q <= desc_i.addr;
      c_q    <= desc_i.c_first;
      cl_q   <= desc_i.c_last;
      odd_q  <= desc_i.col_odd;
      bits_q <= desc_i.bits;
    end else if (fire) begin
      // advance one pixel
      addr_q <= addr_q + grbyuv_pkg::ADDR_W'(2);
      c_q    <= c_q + grbyuv_pkg::COL_W'(1);
      odd_q  <= !odd_q;
    end
    if (fire) begin
      out_addr_q   <= addr_q;
      out_luma_q   <= ent[23:16];
      out_chroma_q <= odd_q ? ent[7:0] : ent[15:8];
      out_last_q   <= last_px;
    end
  end

  assign wr_o.valid         = out_v_q;
  assign wr_o.write_address = out_addr_q;
  assign wr_o.luma_byte     = out_luma_q;
  assign wr_o.chroma_byte   = out_chroma_q;
  assign wr_o.last_write    = out_last_q;

`ifndef SYNTHESIS
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (c_q <= cl_q))
    else $error("back: column counter ran past the row's end");
  a_row_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last_px && !pop_valid_i) |=> !busy_q)
    else $error("back: still busy after the final pixel");
`endif

endmodule
`default_nettype wire

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import grbyuv_pkg::*;

  // Generous ceiling: ~500 rows, 11 writes each, every write behind the longest sink stall
  localparam int unsigned CYCLE_LIMIT = 500000;
  // Cycles to let an in-flight, write-less row leave the pipe before a register write
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic signed [COORD_W-1:0] glyph_x;
    logic signed [COORD_W-1:0] glyph_y;
    logic [ROFF_W-1:0]         row_offset;
    logic [BITS_W-1:0]         row_bits;
    logic                      interlaced;
    logic                      field_parity;
    logic [ADDR_W-1:0]         base_address;
  } glyph_row_t;

  typedef struct {
    logic [ADDR_W-1:0] write_address;
    logic [BYTE_W-1:0] luma_byte;
    logic [BYTE_W-1:0] chroma_byte;
    logic              last_write;
  } pixel_write_t;

  logic clk_i;
  logic rst_ni;

  grbyuv_item_if item_bus ();
  grbyuv_cfg_if  cfg_bus ();
  grbyuv_wr_if   wr_bus ();

  glyph_row_blit_yuv422_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_bus),
    .cfg_i  (cfg_bus),
    .wr_o   (wr_bus)
  );

  // Shadow copy of the block's registers, updated on each config beat
  logic [DIM_W-1:0]    fb_width_r;
  logic [DIM_W-1:0]    fb_height_r;
  logic [STRIDE_W-1:0] row_stride_r;
  logic [PAL_W-1:0]    palette_r [4];

  glyph_row_t   row_queue [$];      // rows waiting for the driver
  glyph_row_t   row_on_bus;         // row currently presented on item_bus
  pixel_write_t pending_writes [$]; // framebuffer writes still owed by the block

  bit          row_beat;
  bit          calm;
  int          src_gap;
  int          sink_stall;
  int          errors;
  int          rows_accepted;
  int          writes_checked;
  int          settings_run;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Work out every framebuffer write one glyph row causes and queue them in order.
  function automatic void blit_row(glyph_row_t r);
    pixel_write_t row_writes [$];
    pixel_write_t w;
    int           gx;
    int           line;
    int           col;
    logic [31:0]  fb_row;
    logic [1:0]   pix;
    logic [23:0]  ent;
    gx = int'(r.glyph_x);
    line = int'(r.glyph_y) + int'(r.row_offset);
    // Drop rows past the glyph, lines off the top or bottom, wrong-field lines
    if (int'(r.row_offset) >= GLYPH_HEIGHT) return;
    if (line < 0 || line >= int'(fb_height_r)) return;
    fb_row = line;
    if (r.interlaced) begin
      if (fb_row[0] != r.field_parity) return;
      fb_row = fb_row >> 1;
    end
    // Drop glyphs lying wholly left of the screen
    if (gx + GLYPH_WIDTH <= 0) return;
    for (int c = 0; c < GLYPH_WIDTH; c++) begin
      col = gx + c;
      if (col < 0 || col >= int'(fb_width_r)) continue;
      pix = r.row_bits[30-2*c +: 2];
      ent = palette_r[pix];
      w.write_address = r.base_address + fb_row * {16'd0, row_stride_r} + 32'(col * 2);
      w.luma_byte     = ent[23:16];
      w.chroma_byte   = col[0] ? ent[7:0] : ent[15:8];
      w.last_write    = 1'b0;
      row_writes.push_back(w);
    end
    if (row_writes.size() != 0) row_writes[row_writes.size()-1].last_write = 1'b1;
    foreach (row_writes[i]) pending_writes.push_back(row_writes[i]);
  endfunction

  function automatic void queue_row(int x, int y, int roff, logic [31:0] bits, bit ilace,
                                    bit par, logic [31:0] base);
    glyph_row_t r;
    r.glyph_x      = x[COORD_W-1:0];
    r.glyph_y      = y[COORD_W-1:0];
    r.row_offset   = roff[ROFF_W-1:0];
    r.row_bits     = bits;
    r.interlaced   = ilace;
    r.field_parity = par;
    r.base_address = base;
    row_queue.push_back(r);
  endfunction

  // Mostly rows that land on screen with random content; the rest are raw noise.
  function automatic void queue_random_row();
    glyph_row_t r;
    int         roff;
    int         line;
    int         x;
    if ($urandom_range(0, 4) != 0) begin
      roff = $urandom_range(0, GLYPH_HEIGHT - 1);
      line = (fb_height_r == 0) ? 0 : int'($urandom_range(0, int'(fb_height_r) - 1));
      // Span from one column past wholly-left to just beyond the right edge
      x = int'($urandom_range(0, int'(fb_width_r) + GLYPH_WIDTH + 1)) - (GLYPH_WIDTH + 1);
      if (x > 4095) x = 4095;
      r.glyph_x      = x[COORD_W-1:0];
      r.glyph_y      = 13'(line - roff);
      r.row_offset   = roff[ROFF_W-1:0];
      r.interlaced   = 1'($urandom_range(0, 1));
      r.field_parity = ($urandom_range(0, 3) == 0) ? ~line[0] : line[0];
    end else begin
      r.glyph_x      = 13'($urandom);
      r.glyph_y      = 13'($urandom);
      r.row_offset   = 4'($urandom);
      r.interlaced   = 1'($urandom_range(0, 1));
      r.field_parity = 1'($urandom_range(0, 1));
    end
    r.row_bits     = $urandom;
    r.base_address = $urandom;
    row_queue.push_back(r);
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    case (idx)
      CFG_FB_WIDTH:   fb_width_r   = value[DIM_W-1:0];
      CFG_FB_HEIGHT:  fb_height_r  = value[DIM_W-1:0];
      CFG_ROW_STRIDE: row_stride_r = value[STRIDE_W-1:0];
      CFG_PAL_ZERO:   palette_r[0] = value;
      CFG_PAL_ONE:    palette_r[1] = value;
      CFG_PAL_TWO:    palette_r[2] = value;
      CFG_PAL_THREE:  palette_r[3] = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Hold until every row is in and every owed write is out, then let the pipe go quiet.
  task automatic settle();
    while (row_queue.size() != 0 || item_bus.valid) @(posedge clk_i);
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_setting(int w, int h, int stride, logic [PAL_W-1:0] p0,
                             logic [PAL_W-1:0] p1, logic [PAL_W-1:0] p2,
                             logic [PAL_W-1:0] p3, int rows);
    write_reg(CFG_FB_WIDTH, 24'(w));
    write_reg(CFG_FB_HEIGHT, 24'(h));
    write_reg(CFG_ROW_STRIDE, 24'(stride));
    write_reg(CFG_PAL_ZERO, p0);
    write_reg(CFG_PAL_ONE, p1);
    write_reg(CFG_PAL_TWO, p2);
    write_reg(CFG_PAL_THREE, p3);
    settings_run++;
    repeat (rows) queue_random_row();
    settle();
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Count acceptance at the rising edge and predict the writes the row owes.
  always @(posedge clk_i) begin
    row_beat = rst_ni && item_bus.valid && item_bus.ready;
    if (row_beat) begin
      rows_accepted++;
      blit_row(row_on_bus);
    end
  end

  // Row driver: advance on a beat or when idle, with random gap bursts between rows.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      item_bus.valid <= 1'b0;
    end else if (!item_bus.valid || row_beat) begin
      if (src_gap > 0) begin
        src_gap--;
        item_bus.valid <= 1'b0;
      end else if (row_queue.size() != 0) begin
        row_on_bus = row_queue.pop_front();
        item_bus.glyph_x      <= row_on_bus.glyph_x;
        item_bus.glyph_y      <= row_on_bus.glyph_y;
        item_bus.row_offset   <= row_on_bus.row_offset;
        item_bus.row_bits     <= row_on_bus.row_bits;
        item_bus.interlaced   <= row_on_bus.interlaced;
        item_bus.field_parity <= row_on_bus.field_parity;
        item_bus.base_address <= row_on_bus.base_address;
        item_bus.valid        <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 13);
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  // Write sink backpressure: drop ready in random bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      wr_bus.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      wr_bus.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      sink_stall = $urandom_range(0, 12);
      wr_bus.ready <= 1'b0;
    end else begin
      wr_bus.ready <= 1'b1;
    end
  end

  // Write monitor: compare each beat with the oldest owed write.
  always @(posedge clk_i) begin
    pixel_write_t owed;
    if (rst_ni && wr_bus.valid && wr_bus.ready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t ns: unexpected write, expected none, actual addr %h luma %h chroma %h",
                 $time, wr_bus.write_address, wr_bus.luma_byte, wr_bus.chroma_byte);
        errors++;
      end else begin
        owed = pending_writes.pop_front();
        check_field("write_address", owed.write_address, wr_bus.write_address);
        check_field("luma_byte", 32'(owed.luma_byte), 32'(wr_bus.luma_byte));
        check_field("chroma_byte", 32'(owed.chroma_byte), 32'(wr_bus.chroma_byte));
        check_field("last_write", 32'(owed.last_write), 32'(wr_bus.last_write));
        writes_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d writes still owed", cycle_count,
               pending_writes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    // Known values on every block input from time zero
    rst_ni                = 1'b0;
    item_bus.valid        = 1'b0;
    item_bus.glyph_x      = '0;
    item_bus.glyph_y      = '0;
    item_bus.row_offset   = '0;
    item_bus.row_bits     = '0;
    item_bus.interlaced   = 1'b0;
    item_bus.field_parity = 1'b0;
    item_bus.base_address = '0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = CFG_FB_WIDTH;
    cfg_bus.data          = '0;
    wr_bus.ready          = 1'b0;
    fb_width_r            = FB_WIDTH_RST;
    fb_height_r           = FB_HEIGHT_RST;
    row_stride_r          = ROW_STRIDE_RST;
    palette_r[0]          = PAL0_RST;
    palette_r[1]          = PAL1_RST;
    palette_r[2]          = PAL2_RST;
    palette_r[3]          = PAL3_RST;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows against the reset registers: 640 x 480, stride 1280
    queue_row(0, 0, 0, 32'h1B1B1B1B, 0, 0, 32'h0000_0000);       // all four palette entries
    queue_row(1, 2, 3, 32'hFFFF_FFFF, 0, 0, 32'h1000_0000);      // odd first column
    queue_row(-10, 0, 0, 32'hAAAA_AAAA, 0, 0, 32'h0000_4000);    // one pixel peeks in on the left
    queue_row(-11, 0, 0, 32'hFFFF_FFFF, 0, 0, 32'h0000_4000);    // wholly left of screen
    queue_row(-12, 5, 0, 32'hFFFF_FFFF, 0, 0, 32'h0000_4000);    // further left
    queue_row(-4096, -4096, 0, 32'h1234_5678, 0, 0, 32'h0);      // most negative coordinates
    queue_row(4095, 4095, 15, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF); // largest fields
    queue_row(0, 0, 14, 32'hFFFF_FFFF, 0, 0, 32'h0);             // row beyond glyph
    queue_row(0, 0, 13, 32'hE4E4_E4E4, 0, 0, 32'h0);             // last glyph row
    queue_row(20, -1, 0, 32'hFFFF_FFFF, 0, 0, 32'h0);            // line above screen
    queue_row(20, -5, 5, 32'h5555_5555, 0, 0, 32'h0);            // offset brings it to line 0
    queue_row(30, 479, 0, 32'h5555_5555, 0, 0, 32'h8000_0000);   // bottom line
    queue_row(30, 476, 4, 32'hFFFF_FFFF, 0, 0, 32'h8000_0000);   // line below screen
    queue_row(635, 100, 0, 32'hC3C3_C3C3, 0, 0, 32'h0);          // clipped on the right
    queue_row(639, 100, 1, 32'hC3C3_C3C3, 0, 0, 32'h0);          // one pixel at the right edge
    queue_row(640, 100, 2, 32'hFFFF_FFFF, 0, 0, 32'h0);          // just off the right edge
    queue_row(4095, 10, 0, 32'hFFFF_FFFF, 0, 0, 32'h0);          // far off the right edge
    queue_row(8, 10, 0, 32'h9999_9999, 1, 0, 32'h0);             // even field, even line
    queue_row(8, 11, 0, 32'h9999_9999, 1, 0, 32'h0);             // even field, odd line dropped
    queue_row(9, 11, 0, 32'h6666_6666, 1, 1, 32'h0);             // odd field, odd line
    queue_row(9, -2, 13, 32'h3333_3333, 1, 1, 32'h0);            // odd field via row offset
    queue_row(2, 479, 0, 32'hDEAD_BEEF, 1, 1, 32'h0100_0000);    // odd field, bottom line
    queue_row(0, 3, 0, 32'h0000_0000, 0, 0, 32'hFFFF_FFF0);      // address wraps past 2^32
    queue_row(100, -4096, 13, 32'hFFFF_FFFF, 0, 0, 32'h0);       // far above screen
    queue_row(-1, 200, 0, 32'hE4E4_E4E4, 0, 1, 32'h0000_0002);   // left clip by one
    settle();

    // Register extremes, degenerate screens that clip everything, then a one-pixel screen
    run_setting(4095, 4095, 65535, 24'hFF_FFFF, 24'h00_0000, 24'($urandom), 24'($urandom),
                60);
    run_setting(0, 480, 1280, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                16);
    run_setting(640, 0, 1280, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                16);
    run_setting(1, 1, 0, 24'h00_0000, 24'hFF_FFFF, 24'($urandom), 24'($urandom), 40);

    // Narrow random screens keep the right-edge clip busy
    repeat (4) begin
      run_setting($urandom_range(1, 80), $urandom_range(1, 300), $urandom_range(0, 65535),
                  24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 60);
    end

    // Final stretch: both sides run flat out
    calm = 1'b1;
    run_setting($urandom_range(600, 4095), 4095, $urandom_range(0, 65535),
                24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 60);

    $display("%0d glyph rows accepted under %0d register settings plus reset defaults",
             rows_accepted, settings_run);
    $display("%0d pixel writes checked, %0d mismatches", writes_checked, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
